// ----- rtl/core/ula_pkg.sv -----
// Shared types and constants for the UART line assembler.
`timescale 1ns / 1ps
`default_nettype none

package ula_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_BELL    = 2'd1;
    localparam logic [1:0] KIND_EOF     = 2'd2;
    localparam logic [1:0] KIND_OVERRUN = 2'd3;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_HIGH  = 8'hA0;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_error;
        logic       overrun;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } out_item_t;

    // Commands from the classifier to the line engine
    typedef enum logic [1:0] {
        OP_STORE,
        OP_FLUSH,
        OP_EOF,
        OP_OVERRUN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] data;
    } cmd_t;

endpackage : ula_pkg

`default_nettype wire

// ----- rtl/core/uart_line_assembler.sv -----
// Top level of the UART line assembler: classifier, command queue, line engine.
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    in_item   (rx_byte, frame_error, overrun)
//  out       output     out_valid/out_ready  out_item  (kind, data, last)
//
// The classifier takes one byte transfer per cycle while the two-entry command
// queue has room. Stored characters and errors are handled in the idle state of the
// line engine; a line end with stored characters goes to the drain sequencer, which
// reads the line store one entry per cycle while the result register is free (it
// enters the drain, gives one result per stored character, then the line feed).
// An empty line gives the line feed alone. rst_n clears all control state and
// empties the line; the line store itself is not cleared. A stall on out_ready
// holds the result register and backs up into the queue, then into in_ready.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_assembler
    import ula_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    // classifier -> queue
    logic f_valid;
    logic f_ready;
    cmd_t f_cmd;

    // queue -> line engine
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    // Classify each transfer: errors, line end, printable, or drop
    ula_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    // Decouple the classifier from a draining line engine
    ula_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    // Store characters, drain lines, and report bell and errors
    ula_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule : uart_line_assembler

`default_nettype wire

// ----- rtl/core/ula_front.sv -----
// Input classifier: maps each received byte to a line command or drops it.
`timescale 1ns / 1ps
`default_nettype none

module ula_front
    import ula_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    logic       stage_valid_reg;
    logic       stage_valid_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       keep;
    logic [7:0] ch_lf;
    logic [7:0] ch_sp;

    assign in_ready  = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        ch_lf = (in_item.rx_byte == CH_CR) ? CH_LF : in_item.rx_byte;
        ch_sp = (ch_lf == CH_TAB) ? CH_SPACE : ch_lf;
        keep          = 1'b1;
        cmd_next.op   = OP_STORE;
        cmd_next.data = ch_sp;
        priority if (in_item.frame_error)
        begin
            cmd_next.op = OP_EOF;
        end
        else if (in_item.overrun)
        begin
            cmd_next.op = OP_OVERRUN;
        end
        else if (ch_lf == CH_LF)
        begin
            cmd_next.op = OP_FLUSH;
        end
        else if ((ch_sp >= CH_SPACE && ch_sp <= CH_TILDE) || ch_sp >= CH_HIGH)
        begin
            cmd_next.op = OP_STORE;
        end
        else
        begin
            // drop other control bytes
            keep = 1'b0;
        end

        if (in_valid && in_ready)
            stage_valid_next = keep;
        else if (cmd_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            cmd_reg <= cmd_next;
    end

endmodule : ula_front

`default_nettype wire

// ----- rtl/core/ula_cmd_fifo.sv -----
// Two-entry command queue between the classifier and the line engine.
`timescale 1ns / 1ps
`default_nettype none

module ula_cmd_fifo
    import ula_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    localparam int Depth = 2;
    localparam int PtrW  = 1;
    localparam int CntW  = 2;

    cmd_t            slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] cnt_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (cnt_reg != CntW'(Depth));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PtrW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CntW'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule : ula_cmd_fifo

`default_nettype wire

// ----- rtl/core/ula_back.sv -----
// Line engine: line store, fill count, drain sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

module ula_back
    import ula_pkg::*;
#(
    parameter int LINE_DEPTH = 64
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_item
);

    localparam int StoreCap = LINE_DEPTH - 1;
    localparam int AddrW    = $clog2(LINE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_TAIL
    } state_t;

    state_t           state_reg,   state_next;
    logic [AddrW-1:0] count_reg,   count_next;
    logic [AddrW-1:0] rd_ptr_reg,  rd_ptr_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg,  out_item_next;
    logic             out_free;
    logic             wr_en;
    logic [7:0]       mem [StoreCap];
    logic [7:0]       rd_data_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_item_next  = out_item_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_STORE:
                        begin
                            if (count_reg == AddrW'(StoreCap))
                            begin
                                if (out_free)
                                begin
                                    cmd_ready      = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_item_next  = '{kind: KIND_BELL, data: 8'h00, last: 1'b1};
                                end
                            end
                            else
                            begin
                                cmd_ready  = 1'b1;
                                wr_en      = 1'b1;
                                count_next = count_reg + AddrW'(1);
                            end
                        end
                        OP_FLUSH:
                        begin
                            if (count_reg == '0)
                            begin
                                if (out_free)
                                begin
                                    cmd_ready      = 1'b1;
                                    out_valid_next = 1'b1;
                                    out_item_next  = '{kind: KIND_CHAR, data: CH_LF, last: 1'b1};
                                end
                            end
                            else
                            begin
                                cmd_ready  = 1'b1;
                                state_next = ST_DRAIN;
                            end
                        end
                        OP_EOF:
                        begin
                            if (out_free)
                            begin
                                cmd_ready      = 1'b1;
                                count_next     = '0;
                                out_valid_next = 1'b1;
                                out_item_next  = '{kind: KIND_EOF, data: 8'h00, last: 1'b1};
                            end
                        end
                        OP_OVERRUN:
                        begin
                            if (out_free)
                            begin
                                cmd_ready      = 1'b1;
                                count_next     = '0;
                                out_valid_next = 1'b1;
                                out_item_next  = '{kind: KIND_OVERRUN, data: 8'h00, last: 1'b1};
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b0;
                        end
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{kind: KIND_CHAR, data: rd_data_reg, last: 1'b0};
                    if (rd_ptr_reg + AddrW'(1) == count_reg)
                    begin
                        rd_ptr_next = '0;
                        state_next  = ST_TAIL;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AddrW'(1);
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = '{kind: KIND_CHAR, data: CH_LF, last: 1'b1};
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end

    // Line store: write at the fill count, read the next drain address
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg] <= cmd.data;
        rd_data_reg <= mem[rd_ptr_next];
    end

endmodule : ula_back

`default_nettype wire
